>>> design/ttsc_pkg.sv
package ttsc_pkg;

  // Field widths
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned DQ_W     = 2 * RATE_W;          // shared divide/multiply shift reg
  localparam int unsigned MS_PER_S = 1000;
  localparam int unsigned REST_W   = $clog2(MS_PER_S);    // width of ms % 1000
  localparam int unsigned NUM_W    = REST_W + RATE_W + 1; // rest * rate + 999
  localparam int unsigned STEP_W   = $clog2(NUM_W);

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(RATE_W - 1);
  localparam logic [STEP_W-1:0] PDIV_LAST = STEP_W'(NUM_W - 1);
  localparam logic [RATE_W-1:0] MS_DIVISOR = RATE_W'(MS_PER_S);
  localparam logic [NUM_W-1:0]  CEIL_ADD   = NUM_W'(MS_PER_S - 1);
  localparam logic [RATE_W-1:0] LEN_SAT    = '1;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICKS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MS     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [RATE_W-1:0] amount;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0]  tick_count;
    logic [CNT_W-1:0]  uptime;
    logic [RATE_W-1:0] armed_length;
    logic              wake;
    logic              sleeping;
  } out_t;

endpackage

>>> design/tick_timer_with_sleep_conversion.sv
// Tick timer with sleep arming and millisecond-to-tick conversion.
// Input channel (in_valid_i/in_ready_o, in_data_i): one transaction per tick,
// sleep-in-ticks, sleep-in-ms or query item. Every input transaction yields
// exactly one output transaction (out_valid_o/out_ready_i, out_data_o) with the
// tick count, uptime in seconds, armed sleep length, wake and sleeping flags.
// Config: cfg_we_i writes cfg_wdata_i into the tick rate; write only while idle.
// Datapath: all arithmetic runs one bit per cycle through a single shared
// shift-subtract / shift-add unit. Tick, tick-sleep and query items run only
// the uptime divide, which is skipped when the rate is zero. A ms sleep adds
// a 32-step divide by 1000, a 32-step multiply by the rate, a second 32-step
// multiply and a 43-step ceiling divide; a saturated whole-seconds product
// skips the last two. A ms sleep with the rate zero skips all the arithmetic.
// One item is in flight at a time; the next is taken in the cycle after the result
// has been moved into the output register, so a stalled receiver holds at most
// one result while the next item is already being worked on.
// Reset clears the tick count, the armed sleep and the rate (rate zero: uptime
// reads 0 and ms sleeps wake at once). The output register holds its value
// while out_ready_i is low.
module tick_timer_with_sleep_conversion (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ttsc_pkg::RATE_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ttsc_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ttsc_pkg::out_t                out_data_o
);
  import ttsc_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MSDIV = 3'd1; // ms / 1000 and ms % 1000
  localparam logic [2:0] S_MULW  = 3'd2; // seconds * rate
  localparam logic [2:0] S_MULR  = 3'd3; // rest * rate
  localparam logic [2:0] S_PDIV  = 3'd4; // (rest * rate + 999) / 1000
  localparam logic [2:0] S_UPLD  = 3'd5; // load uptime divide
  localparam logic [2:0] S_UPDIV = 3'd6; // count / rate
  localparam logic [2:0] S_OUT   = 3'd7; // hand result to output register

  logic [2:0]        state_q, state_d;
  logic [RATE_W-1:0] rate_q, rate_d;
  logic [CNT_W-1:0]  tick_cnt_q, tick_cnt_d;
  logic [CNT_W-1:0]  start_q, start_d;
  logic [RATE_W-1:0] len_q, len_d;
  logic              armed_q, armed_d;
  logic              wake_q, wake_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  // Shared serial arithmetic unit
  logic [RATE_W-1:0] div_r_q, div_r_d;   // partial remainder
  logic [DQ_W-1:0]   div_q_q, div_q_d;   // dividend/quotient or product
  logic [RATE_W-1:0] div_d_q, div_d_d;   // divisor or multiplicand
  logic [STEP_W-1:0] step_q, step_d;
  logic [REST_W-1:0] rest_q, rest_d;
  logic [RATE_W-1:0] whole_q, whole_d;
  logic [CNT_W-1:0]  uptime_q, uptime_d;

  logic [RATE_W:0]   shifted, sub;
  logic              ge;
  logic [RATE_W-1:0] r_next;
  logic [DQ_W-1:0]   q_next, p_next;
  logic [RATE_W:0]   mul_sum;
  logic [CNT_W-1:0]  cnt_inc;
  logic [NUM_W-1:0]  num;
  logic [RATE_W:0]   len_sum;
  logic              arm_en;
  logic [RATE_W-1:0] arm_len;
  logic              in_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Restoring divide step
  assign shifted = {div_r_q, div_q_q[DQ_W-1]};
  assign ge      = (shifted >= {1'b0, div_d_q});
  assign sub     = shifted - {1'b0, div_d_q};
  assign r_next  = ge ? sub[RATE_W-1:0] : shifted[RATE_W-1:0];
  assign q_next  = {div_q_q[DQ_W-2:0], ge};

  // Shift-add multiply step, multiplier in the low half, LSB first
  assign mul_sum = {1'b0, div_q_q[DQ_W-1:RATE_W]}
                 + (div_q_q[0] ? {1'b0, div_d_q} : {(RATE_W+1){1'b0}});
  assign p_next  = {mul_sum, div_q_q[RATE_W-1:1]};

  assign cnt_inc = tick_cnt_q + 1'b1;
  // product of rest and rate fits in REST_W + RATE_W bits
  assign num     = {1'b0, p_next[REST_W+RATE_W-1:0]} + CEIL_ADD;
  assign len_sum = {1'b0, whole_q} + {1'b0, q_next[RATE_W-1:0]};

  always_comb begin
    state_d     = state_q;
    rate_d      = cfg_we_i ? cfg_wdata_i : rate_q;
    tick_cnt_d  = tick_cnt_q;
    start_d     = start_q;
    len_d       = len_q;
    armed_d     = armed_q;
    wake_d      = wake_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    div_r_d     = div_r_q;
    div_q_d     = div_q_q;
    div_d_d     = div_d_q;
    step_d      = step_q;
    rest_d      = rest_q;
    whole_d     = whole_q;
    uptime_d    = uptime_q;
    arm_en      = 1'b0;
    arm_len     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          wake_d  = 1'b0;
          state_d = S_UPLD;
          case (in_data_i.kind)
            KIND_TICK: begin
              tick_cnt_d = cnt_inc;
              if (armed_q && ((cnt_inc - start_q) >= len_q)) begin
                armed_d = 1'b0;
                wake_d  = 1'b1;
              end
            end
            KIND_TICKS: begin
              arm_en  = 1'b1;
              arm_len = in_data_i.amount;
            end
            KIND_MS: begin
              if (rate_q == '0) begin
                arm_en = 1'b1;   // no rate: empty sleep
              end else begin
                div_r_d = '0;
                div_q_d = {in_data_i.amount, {RATE_W{1'b0}}};
                div_d_d = MS_DIVISOR;
                step_d  = DIV_LAST;
                state_d = S_MSDIV;
              end
            end
            default: ;
          endcase
        end
      end
      S_MSDIV: begin
        div_r_d = r_next;
        div_q_d = q_next;
        step_d  = step_q - 1'b1;
        if (step_q == '0) begin
          rest_d  = r_next[REST_W-1:0];
          div_q_d = {{RATE_W{1'b0}}, q_next[RATE_W-1:0]};
          div_d_d = rate_q;
          step_d  = DIV_LAST;
          state_d = S_MULW;
        end
      end
      S_MULW: begin
        div_q_d = p_next;
        step_d  = step_q - 1'b1;
        if (step_q == '0) begin
          if (p_next[DQ_W-1:RATE_W] != '0) begin
            arm_en  = 1'b1;
            arm_len = LEN_SAT;
            state_d = S_UPLD;
          end else begin
            whole_d = p_next[RATE_W-1:0];
            div_q_d = {{(DQ_W-REST_W){1'b0}}, rest_q};
            step_d  = DIV_LAST;
            state_d = S_MULR;
          end
        end
      end
      S_MULR: begin
        div_q_d = p_next;
        step_d  = step_q - 1'b1;
        if (step_q == '0) begin
          div_r_d = '0;
          div_q_d = {num, {(DQ_W-NUM_W){1'b0}}};
          div_d_d = MS_DIVISOR;
          step_d  = PDIV_LAST;
          state_d = S_PDIV;
        end
      end
      S_PDIV: begin
        div_r_d = r_next;
        div_q_d = q_next;
        step_d  = step_q - 1'b1;
        if (step_q == '0) begin
          // quotient is at most the rate, so the low half holds it
          arm_en  = 1'b1;
          arm_len = len_sum[RATE_W] ? LEN_SAT : len_sum[RATE_W-1:0];
          state_d = S_UPLD;
        end
      end
      S_UPLD: begin
        if (rate_q == '0) begin
          uptime_d = '0;
          state_d  = S_OUT;
        end else begin
          div_r_d = '0;
          div_q_d = {tick_cnt_q, {(DQ_W-CNT_W){1'b0}}};
          div_d_d = rate_q;
          step_d  = DIV_LAST;
          state_d = S_UPDIV;
        end
      end
      S_UPDIV: begin
        div_r_d = r_next;
        div_q_d = q_next;
        step_d  = step_q - 1'b1;
        if (step_q == '0) begin
          uptime_d = q_next[CNT_W-1:0];
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.tick_count   = tick_cnt_q;
          out_d.uptime       = uptime_q;
          out_d.armed_length = armed_q ? len_q : '0;
          out_d.wake         = wake_q;
          out_d.sleeping     = armed_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Arming: a zero length cancels any sleep and wakes at once
    if (arm_en) begin
      if (arm_len == '0) begin
        armed_d = 1'b0;
        len_d   = '0;
        wake_d  = 1'b1;
      end else begin
        armed_d = 1'b1;
        start_d = tick_cnt_q;
        len_d   = arm_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rate_q      <= '0;
      tick_cnt_q  <= '0;
      start_q     <= '0;
      len_q       <= '0;
      armed_q     <= 1'b0;
      wake_q      <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      rate_q      <= rate_d;
      tick_cnt_q  <= tick_cnt_d;
      start_q     <= start_d;
      len_q       <= len_d;
      armed_q     <= armed_d;
      wake_q      <= wake_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    div_r_q  <= div_r_d;
    div_q_q  <= div_q_d;
    div_d_q  <= div_d_d;
    rest_q   <= rest_d;
    whole_q  <= whole_d;
    uptime_q <= uptime_d;
  end

endmodule
